// ===== hw/rtl/ordered_list_append_remove_search_macros.svh =====
// Assertion macros for the ordered list block.
`ifndef ORDERED_LIST_APPEND_REMOVE_SEARCH_MACROS_SVH
`define ORDERED_LIST_APPEND_REMOVE_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
`define OLIST_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list check failed");
`define OLIST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list check failed");
`else
`define OLIST_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define OLIST_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/olist_pkg.sv =====
// Widths, codes and defaults shared by the ordered list block.
package olist_pkg;

   localparam int CAPACITY_DEFAULT = 32;

   localparam int CMD_W    = 2;
   localparam int ID_W     = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 5;
   localparam int COUNT_W  = 6;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_POS   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

endpackage

// ===== hw/rtl/ordered_list_append_remove_search.sv =====
// Bounded ordered list of identifiers: append, remove at position, search.
//
//   channel   ports                                         direction
//   req       req_valid req_ready req_cmd req_song_id         in
//             req_position
//   rsp       rsp_valid rsp_ready rsp_status                  out
//             rsp_found_index rsp_entry_count
//
// Append, unused codes and rejected commands go straight to the finish state; search and
// remove walk the entry memory through its single read port, one entry a cycle, search from
// entry 0 and remove from position + 1 to the end. A new command is taken only once the previous result
// has moved to the output register. Reset clears the count and handshake state; the
// entry memory is not cleared. A stalled rsp holds the next result in the finish state
// until the output register frees.
`include "ordered_list_append_remove_search_macros.svh"

module ordered_list_append_remove_search
   import olist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic signed [ID_W-1:0]     req_song_id,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [INDEX_W-1:0]         rsp_found_index,
   output logic [COUNT_W-1:0]         rsp_entry_count
);

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SEARCH = 2'd1;
   localparam logic [1:0] S_REMOVE = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   logic signed [ID_W-1:0] mem [0:CAPACITY-1];
   logic signed [ID_W-1:0] rd_data_ff;

   logic [1:0]             state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          ptr_ff, ptr_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          pend_idx_ff, pend_idx_in;
   logic signed [ID_W-1:0] id_ff, id_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [INDEX_W-1:0]     res_index_ff, res_index_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic                   req_fire;
   logic                   has_room;
   logic                   pos_bad;
   logic                   scan_more;
   logic                   hit;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic signed [ID_W-1:0] mem_wdata;
   logic                   mem_re;
   logic [AW-1:0]          mem_raddr;

   assign req_ready       = (state_ff == S_IDLE);
   assign req_fire        = req_valid && req_ready;
   assign has_room        = (count_ff < CAP_COUNT);
   assign pos_bad         = (CMPW'(req_position) >= CMPW'(count_ff));
   assign scan_more       = (ptr_ff < count_ff);
   assign hit             = pend_ff && (rd_data_ff == id_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pend_idx_ff - AW'(1);
      mem_wdata = rd_data_ff;
      if (req_fire && req_cmd == CMD_APPEND && has_room) begin
         mem_we    = 1'b1;
         mem_waddr = count_ff[AW-1:0];
         mem_wdata = req_song_id;
      end else if (state_ff == S_REMOVE && pend_ff) begin
         mem_we = 1'b1;
      end
   end

   assign mem_re    = (state_ff == S_SEARCH || state_ff == S_REMOVE) && scan_more;
   assign mem_raddr = ptr_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      id_in         = id_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               id_in         = req_song_id;
               res_index_in  = '0;
               res_status_in = STATUS_OK;
               pend_in       = 1'b0;
               state_in      = S_FINISH;
               unique case (req_cmd)
                  CMD_APPEND: begin
                     if (has_room) begin
                        count_in = count_ff + CW'(1);
                     end else begin
                        res_status_in = STATUS_FULL;
                     end
                  end
                  CMD_REMOVE: begin
                     if (pos_bad) begin
                        res_status_in = STATUS_BAD_POS;
                     end else begin
                        ptr_in   = CW'(req_position) + CW'(1);
                        state_in = S_REMOVE;
                     end
                  end
                  CMD_SEARCH: begin
                     ptr_in   = '0;
                     state_in = S_SEARCH;
                  end
                  default: begin
                     res_status_in = STATUS_OK;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            if (hit) begin
               res_status_in = STATUS_OK;
               res_index_in  = INDEX_W'(pend_idx_ff);
               pend_in       = 1'b0;
               state_in      = S_FINISH;
            end else if (scan_more) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[AW-1:0];
               ptr_in      = ptr_ff + CW'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               res_status_in = STATUS_NOT_FOUND;
               state_in      = S_FINISH;
            end
         end
         S_REMOVE: begin
            if (scan_more) begin
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[AW-1:0];
               ptr_in      = ptr_ff + CW'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      pend_idx_ff   <= pend_idx_in;
      id_ff         <= id_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

   `OLIST_ASSERT_SAME(a_count_bounded, clock, reset, 1'b1, count_ff <= CAP_COUNT)
   `OLIST_ASSERT_SAME(a_shift_no_overlap, clock, reset, state_ff == S_REMOVE && pend_ff && scan_more, mem_waddr != mem_raddr)
   `OLIST_ASSERT_SAME(a_hit_in_range, clock, reset, state_ff == S_SEARCH && hit, CW'(pend_idx_ff) < count_ff)
   `OLIST_ASSERT_NEXT(a_append_grows, clock, reset, req_fire && req_cmd == CMD_APPEND && has_room, count_ff == $past(count_ff) + CW'(1))

endmodule

// ===== tb/olist_result_checker.sv =====
// Transfer monitor, list predictor and result comparison for the ordered list block.
`timescale 1ns / 1ps

module olist_result_checker
   import olist_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [ID_W-1:0]        req_song_id,
   input  logic [POS_W-1:0]       req_position,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [STATUS_W-1:0]    rsp_status,
   input  logic [INDEX_W-1:0]     rsp_found_index,
   input  logic [COUNT_W-1:0]     rsp_entry_count,
   output int                     fail_count,
   output int                     outstanding,
   output int                     results_checked,
   output int                     full_seen,
   output int                     bad_pos_seen,
   output int                     not_found_seen,
   output int                     peak_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [COUNT_W-1:0]  count;
   } olist_result_type;

   logic [ID_W-1:0]  list_store [CAPACITY];
   int               list_len;
   olist_result_type expected_results [$];

   initial begin
      fail_count      = 0;
      outstanding     = 0;
      results_checked = 0;
      full_seen       = 0;
      bad_pos_seen    = 0;
      not_found_seen  = 0;
      peak_count      = 0;
      list_len        = 0;
   end

   task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                input logic [POS_W-1:0] pos);
      olist_result_type r;
      int               i;
      r.status = STATUS_OK;
      r.index  = '0;
      case (cmd)
         CMD_APPEND: begin
            if (list_len >= CAPACITY) begin
               r.status = STATUS_FULL;
            end else begin
               list_store[list_len] = id;
               list_len++;
            end
         end
         CMD_REMOVE: begin
            if (int'(pos) >= list_len) begin
               r.status = STATUS_BAD_POS;
            end else begin
               for (i = int'(pos); i < list_len - 1; i++) list_store[i] = list_store[i + 1];
               list_len--;
            end
         end
         CMD_SEARCH: begin
            r.status = STATUS_NOT_FOUND;
            for (i = 0; i < list_len; i++) begin
               if (list_store[i] == id) begin
                  r.status = STATUS_OK;
                  r.index  = i[INDEX_W-1:0];
                  break;
               end
            end
         end
         default: ;
      endcase
      r.count = list_len[COUNT_W-1:0];
      if (list_len > peak_count) peak_count = list_len;
      expected_results.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input olist_result_type want);
      if (fail_count < 10)
         $display("%0t: %s: expected status %0d index %0d count %0d, got %0d %0d %0d",
                  $realtime, what, want.status, want.index, want.count,
                  rsp_status, rsp_found_index, rsp_entry_count);
      fail_count++;
   endtask

   always @(posedge clock) begin
      olist_result_type want;
      if (reset) begin
         list_len = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result without a command", '0);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               case (want.status)
                  STATUS_FULL:      full_seen++;
                  STATUS_BAD_POS:   bad_pos_seen++;
                  STATUS_NOT_FOUND: not_found_seen++;
                  default: ;
               endcase
               if (rsp_status !== want.status || rsp_found_index !== want.index ||
                   rsp_entry_count !== want.count)
                  report_mismatch("result mismatch", want);
            end
         end
         if (req_valid && req_ready) apply_command(req_cmd, req_song_id, req_position);
      end
      outstanding = expected_results.size();
   end

   final begin
      if (expected_results.size() != 0) fail_count += expected_results.size();
   end

endmodule

// ===== tb/tb_ordered_list_append_remove_search.sv =====
// Top-level testbench for the ordered list block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_ordered_list_append_remove_search;
   import olist_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int ITEMS_PER_RUN = 550;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CMD_W-1:0]           req_cmd = CMD_APPEND;
   logic signed [ID_W-1:0]     req_song_id = '0;
   logic [POS_W-1:0]           req_position = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [INDEX_W-1:0]         rsp_found_index;
   logic [COUNT_W-1:0]         rsp_entry_count;

   int fail_count, outstanding, results_checked;
   int full_seen, bad_pos_seen, not_found_seen, peak_count;
   int send_idle_pct = 30;
   int recv_idle_pct = 81;
   int stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ordered_list_append_remove_search u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_song_id     (req_song_id),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count)
   );

   olist_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_song_id     (req_song_id),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found_index (rsp_found_index),
      .rsp_entry_count (rsp_entry_count),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .full_seen       (full_seen),
      .bad_pos_seen    (bad_pos_seen),
      .not_found_seen  (not_found_seen),
      .peak_count      (peak_count)
   );

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                            input logic [POS_W-1:0] pos);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_song_id  <= id;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold the sender off until every result has come back
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   function automatic logic [ID_W-1:0] pick_id();
      if ($urandom_range(0, 9) < 3) return $urandom();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return 32'h0000_0001;
         5: return 32'h5555_AAAA;
         6: return 32'hAAAA_5555;
         7: return 32'h0F0F_F0F0;
         8: return 32'h1234_5678;
         default: return 32'hDEAD_0042;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      if ($urandom_range(0, 9) < 6) return POS_W'($urandom_range(0, 3));
      return POS_W'($urandom_range(0, 31));
   endfunction

   initial begin
      int run;
      int sent;
      int roll;
      logic filling;
      logic [CMD_W-1:0] cmd;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(CMD_SEARCH, 32'h7FFF_FFFF, 5'd0);
      send_item(CMD_REMOVE, 32'h0000_0000, 5'd0);
      send_item(CMD_UNUSED, 32'hFFFF_FFFF, 5'd31);
      send_item(CMD_APPEND, 32'h8000_0000, 5'd31);
      send_item(CMD_APPEND, 32'h7FFF_FFFF, 5'd0);
      send_item(CMD_APPEND, 32'h0000_0000, 5'd17);
      send_item(CMD_APPEND, 32'hFFFF_FFFF, 5'd0);
      send_item(CMD_APPEND, 32'h7FFF_FFFF, 5'd0);
      send_item(CMD_APPEND, 32'h0000_0001, 5'd0);
      send_item(CMD_SEARCH, 32'h7FFF_FFFF, 5'd31);
      send_item(CMD_SEARCH, 32'h8000_0000, 5'd0);
      send_item(CMD_SEARCH, 32'h1234_5678, 5'd0);
      send_item(CMD_SEARCH, 32'hFFFF_FFFF, 5'd0);
      send_item(CMD_REMOVE, 32'hFFFF_FFFF, 5'd6);
      send_item(CMD_REMOVE, 32'h0000_0000, 5'd31);
      send_item(CMD_REMOVE, 32'h0000_0000, 5'd5);
      send_item(CMD_REMOVE, 32'h0000_0000, 5'd0);
      send_item(CMD_SEARCH, 32'h7FFF_FFFF, 5'd0);
      send_item(CMD_UNUSED, 32'h8000_0000, 5'd31);
      send_item(CMD_SEARCH, 32'h0000_0001, 5'd0);
      send_item(CMD_REMOVE, 32'h0000_0000, 5'd2);
      send_item(CMD_REMOVE, 32'h0000_0000, 5'd1);
      send_item(CMD_REMOVE, 32'h0000_0000, 5'd0);
      send_item(CMD_REMOVE, 32'h0000_0000, 5'd0);

      for (run = 0; run < 3; run++) begin
         wait_for_drain();
         case (run)
            0: begin send_idle_pct = 30; recv_idle_pct = 81; end
            1: begin send_idle_pct = 81; recv_idle_pct = 30; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         filling = 1'b1;
         sent = 0;
         while (sent < ITEMS_PER_RUN) begin
            if (sent % 100 == 99) filling = !filling;
            roll = $urandom_range(0, 99);
            if (filling)
               cmd = (roll < 60) ? CMD_APPEND : (roll < 75) ? CMD_REMOVE :
                     (roll < 97) ? CMD_SEARCH : CMD_UNUSED;
            else
               cmd = (roll < 12) ? CMD_APPEND : (roll < 72) ? CMD_REMOVE :
                     (roll < 97) ? CMD_SEARCH : CMD_UNUSED;
            send_item(cmd, pick_id(), pick_position());
            if (cmd != CMD_UNUSED) sent++;
            if ($urandom_range(0, 59) == 0) wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (40) @(posedge clock);

      $display("Checked %0d results over three idling regimes; list filled to %0d entries.",
               results_checked, peak_count);
      $display("Outcomes seen: %0d list full, %0d invalid position, %0d not found.",
               full_seen, bad_pos_seen, not_found_seen);
      if (fail_count == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
